// File: design/tis_pkg.sv
`default_nettype none
package tis_pkg;

	localparam int unsigned WORD_W           = 32;
	localparam int unsigned SPACING_W        = 31;
	localparam int unsigned MAX_SEGMENTS_DEF = 32;
	localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd65536;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KMIN_GO,
		ST_KMIN_WT,
		ST_KMAX_GO,
		ST_KMAX_WT,
		ST_SETUP,
		ST_LONG_GO,
		ST_LONG_WT,
		ST_SHORT_GO,
		ST_SHORT_WT,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} state_t;

	// Request to the shared divider: floor({hi, lo} / den), with hi < den.
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quo;
		logic [WORD_W-1:0] rem;
	} div_rsp_t;

endpackage
`default_nettype wire

// File: design/triangle_isoline_segments.sv
`default_nettype none
// Contour segment extractor for one triangle (marching triangles).
// The input channel carries one triangle per transaction: three vertices with
// x, y and a node value, all signed Q16.16. The output channel carries one
// segment per transaction, in ascending level order, with last_segment set on
// the final one and truncated set on all of them when more than MAX_SEGMENTS
// levels cross the triangle. A triangle that crosses no level gives nothing.
// Both channels use valid and stall; a transaction completes when valid is
// high and stall is low. in_stall is high while a triangle is in work.
// level_spacing is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while idle, as the block does not enforce this. All work
// runs on one 32-bit restoring divider and one 32x32 multiplier under a
// small sequencer. Setup takes two divisions; each segment then takes two
// divisions and four multiplies, plus however long the receiver stalls output.
// A segment waits in the output registers until taken; no new triangle is
// accepted until the last segment of the current one has left.
// Reset clears the sequencer and sets level_spacing to 1.0.
module triangle_isoline_segments #(
	parameter int unsigned MAX_SEGMENTS = tis_pkg::MAX_SEGMENTS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_wr_en,
	input  wire         [30:0] cfg_wr_data,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  signed [31:0] vert_a_x,
	input  wire  signed [31:0] vert_a_y,
	input  wire  signed [31:0] vert_a_value,
	input  wire  signed [31:0] vert_b_x,
	input  wire  signed [31:0] vert_b_y,
	input  wire  signed [31:0] vert_b_value,
	input  wire  signed [31:0] vert_c_x,
	input  wire  signed [31:0] vert_c_y,
	input  wire  signed [31:0] vert_c_value,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [31:0] seg_start_x,
	output logic signed [31:0] seg_start_y,
	output logic signed [31:0] seg_end_x,
	output logic signed [31:0] seg_end_y,
	output logic signed [31:0] level_index,
	output logic               last_segment,
	output logic               truncated
);
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

	tis_pkg::state_t state_q, state_d;
	tis_pkg::div_req_t dreq;
	tis_pkg::div_rsp_t drsp;

	logic [30:0] spacing_q;
	logic [30:0] s_eff;

	// Sorted vertices: index 0 lowest value, 2 highest.
	logic signed [31:0] vx_q [3];
	logic signed [31:0] vy_q [3];
	logic signed [31:0] vf_q [3];

	logic signed [32:0] kmin_q;
	logic signed [33:0] lev_q;
	logic signed [31:0] k_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      cnt_q;
	logic               trunc_q;
	logic [31:0]        alpha_l_q;
	logic [31:0]        alpha_s_q;
	logic               lower_q;
	logic [1:0]         mul_idx_q;

	logic [63:0]        prod_s1;
	logic signed [31:0] p_s1;
	logic               neg_s1;
	logic [1:0]         idx_s1;
	logic               vld_s1;

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	assign s_eff = (spacing_q == '0) ? 31'd1 : spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= tis_pkg::SPACING_RESET;
		end else if (cfg_wr_en) begin
			spacing_q <= cfg_wr_data;
		end
	end

	// Vertex ordering, with ties kept in a fixed order.
	logic signed [31:0] fin [3];
	logic [1:0] i0, i1, i2, t0, t1;
	always_comb begin
		fin[0] = vert_a_value;
		fin[1] = vert_b_value;
		fin[2] = vert_c_value;
		if (fin[0] <= fin[1]) begin
			t0 = 2'd0; t1 = 2'd1;
		end else begin
			t0 = 2'd1; t1 = 2'd0;
		end
		if (fin[t1] <= fin[2]) begin
			i2 = 2'd2;
		end else begin
			i2 = t1; t1 = 2'd2;
		end
		if (fin[t0] > fin[t1]) begin
			i0 = t1; i1 = t0;
		end else begin
			i0 = t0; i1 = t1;
		end
	end

	function automatic logic signed [31:0] pick(input logic [1:0] i,
			input logic signed [31:0] a, input logic signed [31:0] b,
			input logic signed [31:0] c);
		case (i)
			2'd0:    pick = a;
			2'd1:    pick = b;
			default: pick = c;
		endcase
	endfunction

	// Magnitude of a signed word and the signed ceiling of word / spacing.
	logic signed [31:0] div_src;
	logic [31:0]        div_mag;
	logic signed [32:0] ceil_q;
	always_comb begin
		div_src = (state_q == tis_pkg::ST_KMAX_GO || state_q == tis_pkg::ST_KMAX_WT)
			? vf_q[2] : vf_q[0];
		div_mag = div_src[31] ? 32'(-33'(div_src)) : 32'(div_src);
		if (div_src[31]) begin
			ceil_q = -$signed({1'b0, drsp.quo});
		end else begin
			ceil_q = $signed({1'b0, drsp.quo}) + 33'(drsp.rem != '0);
		end
	end

	// Level relative to the lower end of the edge being divided.
	logic signed [31:0] sp_f, sq_f;
	always_comb begin
		sp_f = lower_q ? vf_q[0] : vf_q[1];
		sq_f = lower_q ? vf_q[1] : vf_q[2];
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.hi    = '0;
		dreq.lo    = div_mag;
		dreq.den   = {1'b0, s_eff};
		unique case (state_q)
			tis_pkg::ST_KMIN_GO, tis_pkg::ST_KMAX_GO: begin
				dreq.start = 1'b1;
			end
			tis_pkg::ST_LONG_GO: begin
				dreq.start = 1'b1;
				dreq.lo    = '0;
				dreq.hi    = 32'(lev_q - 34'(vf_q[0]));
				dreq.den   = 32'(33'(vf_q[2]) - 33'(vf_q[0]));
			end
			tis_pkg::ST_SHORT_GO: begin
				dreq.start = 1'b1;
				dreq.lo    = '0;
				dreq.hi    = 32'(lev_q - 34'(sp_f));
				dreq.den   = 32'(33'(sq_f) - 33'(sp_f));
			end
			default: ;
		endcase
	end

	tis_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Setup: number of levels from the two ceilings.
	logic signed [33:0] cnt_full;
	assign cnt_full = 34'(ceil_q) - 34'(1) - 34'(kmin_q) + 34'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tis_pkg::ST_IDLE:     if (in_valid) state_d = tis_pkg::ST_KMIN_GO;
			tis_pkg::ST_KMIN_GO:  state_d = tis_pkg::ST_KMIN_WT;
			tis_pkg::ST_KMIN_WT:  if (drsp.done) state_d = tis_pkg::ST_KMAX_GO;
			tis_pkg::ST_KMAX_GO:  state_d = tis_pkg::ST_KMAX_WT;
			tis_pkg::ST_KMAX_WT:  if (drsp.done) state_d = tis_pkg::ST_SETUP;
			tis_pkg::ST_SETUP:    state_d = (cnt_q == '0) ? tis_pkg::ST_IDLE
				: tis_pkg::ST_LONG_GO;
			tis_pkg::ST_LONG_GO:  state_d = tis_pkg::ST_LONG_WT;
			tis_pkg::ST_LONG_WT:  if (drsp.done) state_d = tis_pkg::ST_SHORT_GO;
			tis_pkg::ST_SHORT_GO: state_d = tis_pkg::ST_SHORT_WT;
			tis_pkg::ST_SHORT_WT: if (drsp.done) state_d = tis_pkg::ST_MUL;
			tis_pkg::ST_MUL:      if (mul_idx_q == 2'd3) state_d = tis_pkg::ST_FIN;
			tis_pkg::ST_FIN:      state_d = tis_pkg::ST_OUT;
			tis_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_d = last_segment ? tis_pkg::ST_IDLE : tis_pkg::ST_LONG_GO;
				end
			end
			default:              state_d = tis_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall  = (state_q != tis_pkg::ST_IDLE);
		out_valid = (state_q == tis_pkg::ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tis_pkg::ST_IDLE;
			mul_idx_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == tis_pkg::ST_MUL);
			if (state_q == tis_pkg::ST_MUL) begin
				mul_idx_q <= mul_idx_q + 2'd1;
			end else begin
				mul_idx_q <= '0;
			end
		end
	end

	// Shared multiplier with its operand selection.
	logic signed [31:0] mp, mq;
	logic [31:0]        malpha;
	logic signed [32:0] md;
	logic [31:0]        mmag;
	always_comb begin
		case (mul_idx_q)
			2'd0: begin
				mp = vx_q[0]; mq = vx_q[2]; malpha = alpha_l_q;
			end
			2'd1: begin
				mp = vy_q[0]; mq = vy_q[2]; malpha = alpha_l_q;
			end
			2'd2: begin
				mp = lower_q ? vx_q[0] : vx_q[1];
				mq = lower_q ? vx_q[1] : vx_q[2];
				malpha = alpha_s_q;
			end
			default: begin
				mp = lower_q ? vy_q[0] : vy_q[1];
				mq = lower_q ? vy_q[1] : vy_q[2];
				malpha = alpha_s_q;
			end
		endcase
		md   = 33'(mq) - 33'(mp);
		mmag = md[32] ? 32'(-md) : 32'(md);
	end

	logic signed [31:0] lerp_res;
	assign lerp_res = neg_s1 ? (p_s1 - 32'(prod_s1[63:32]))
		: (p_s1 + 32'(prod_s1[63:32]));

	always_ff @(posedge clk) begin
		if (in_acc) begin
			vx_q[0] <= pick(i0, vert_a_x, vert_b_x, vert_c_x);
			vx_q[1] <= pick(i1, vert_a_x, vert_b_x, vert_c_x);
			vx_q[2] <= pick(i2, vert_a_x, vert_b_x, vert_c_x);
			vy_q[0] <= pick(i0, vert_a_y, vert_b_y, vert_c_y);
			vy_q[1] <= pick(i1, vert_a_y, vert_b_y, vert_c_y);
			vy_q[2] <= pick(i2, vert_a_y, vert_b_y, vert_c_y);
			vf_q[0] <= pick(i0, vert_a_value, vert_b_value, vert_c_value);
			vf_q[1] <= pick(i1, vert_a_value, vert_b_value, vert_c_value);
			vf_q[2] <= pick(i2, vert_a_value, vert_b_value, vert_c_value);
		end

		if (state_q == tis_pkg::ST_KMIN_WT && drsp.done) begin
			kmin_q <= ceil_q;
			k_q    <= 32'(ceil_q);
			// First level at or above the lowest value, without a multiply.
			if (vf_q[0][31]) begin
				lev_q <= 34'(vf_q[0]) + 34'(drsp.rem);
			end else begin
				lev_q <= 34'(vf_q[0]) - 34'(drsp.rem)
					+ ((drsp.rem != '0) ? 34'(s_eff) : 34'(0));
			end
		end

		if (state_q == tis_pkg::ST_KMAX_WT && drsp.done) begin
			n_q <= '0;
			if (cnt_full <= 0) begin
				cnt_q   <= '0;
				trunc_q <= 1'b0;
			end else if (cnt_full > 34'(MAX_SEGMENTS)) begin
				cnt_q   <= CW'(MAX_SEGMENTS);
				trunc_q <= 1'b1;
			end else begin
				cnt_q   <= CW'(cnt_full);
				trunc_q <= 1'b0;
			end
		end

		if (state_q == tis_pkg::ST_LONG_GO) begin
			lower_q <= (lev_q < 34'(vf_q[1]));
		end
		if (state_q == tis_pkg::ST_LONG_WT && drsp.done) begin
			alpha_l_q <= drsp.quo;
		end
		if (state_q == tis_pkg::ST_SHORT_WT && drsp.done) begin
			alpha_s_q <= drsp.quo;
		end

		prod_s1 <= 64'(malpha) * 64'(mmag);
		p_s1    <= mp;
		neg_s1  <= md[32];
		idx_s1  <= mul_idx_q;

		if (vld_s1) begin
			case (idx_s1)
				2'd0:    seg_start_x <= lerp_res;
				2'd1:    seg_start_y <= lerp_res;
				2'd2:    seg_end_x   <= lerp_res;
				default: seg_end_y   <= lerp_res;
			endcase
		end

		if (state_q == tis_pkg::ST_FIN) begin
			level_index  <= k_q;
			last_segment <= (n_q + CW'(1) == cnt_q);
			truncated    <= trunc_q;
		end

		if (out_acc) begin
			lev_q <= lev_q + 34'(s_eff);
			k_q   <= k_q + 32'sd1;
			n_q   <= n_q + CW'(1);
		end
	end

endmodule
`default_nettype wire

// File: design/tis_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle while busy.
module tis_divider (
	input  wire              clk,
	input  wire              arst_n,
	input  tis_pkg::div_req_t req,
	output tis_pkg::div_rsp_t rsp
);
	localparam int unsigned W     = tis_pkg::WORD_W;
	localparam int unsigned CNT_W = $clog2(W);

	logic [W-1:0]           rem_q;
	logic [W-1:0]           sh_q;
	logic [W-1:0]           den_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [W:0]             trial;
	logic                   fits;

	always_comb begin
		trial = {rem_q, sh_q[W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.hi;
			sh_q  <= req.lo;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
			sh_q  <= {sh_q[W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sh_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire
